// ----- src/trq_pkg.sv -----
// Shared types and constants of the task ready queue.
`default_nettype none

package trq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ID_BITS     = 8;
  localparam int KIND_BITS       = 3;
  localparam int MIN_ROTATE      = 2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_APPEND = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_ROTATE = 3'd2,
    KIND_PEEK   = 3'd3,
    KIND_CLEAR  = 3'd4
  } op_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FETCH,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- src/trq_if.sv -----
// Command and result channel interfaces of the task ready queue.
`default_nettype none

interface trq_cmd_if import trq_pkg::*; #(
  parameter int ID_BITS = DEF_ID_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic [KIND_BITS-1:0] kind;
  logic [ID_BITS-1:0]   task_id;

  modport source (output valid, kind, task_id, input ready);
  modport sink   (input valid, kind, task_id, output ready);
endinterface

interface trq_res_if import trq_pkg::*; #(
  parameter int ID_BITS  = DEF_ID_BITS,
  parameter int CNT_BITS = $clog2(DEF_QUEUE_DEPTH + 1)
) ();
  logic                valid;
  logic                ready;
  logic                success;
  logic                id_valid;
  logic [ID_BITS-1:0]  returned_id;
  logic [CNT_BITS-1:0] entry_count;

  modport source (output valid, success, id_valid, returned_id, entry_count, input ready);
  modport sink   (input valid, success, id_valid, returned_id, entry_count, output ready);
endinterface

`default_nettype wire

// ----- src/trq_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module trq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/trq_ctrl.sv -----
// Operation sequencer of the task ready queue: read-modify-write over the id RAM.
`default_nettype none

module trq_ctrl import trq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS,
  localparam int IDX_BITS   = $clog2(QUEUE_DEPTH),
  localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  trq_cmd_if.sink                  cmd,
  trq_res_if.source                res,
  output logic                     ram_we,
  output logic      [IDX_BITS-1:0] ram_waddr,
  output logic      [ID_BITS-1:0]  ram_wdata,
  output logic                     ram_re,
  output logic      [IDX_BITS-1:0] ram_raddr,
  input  wire logic [ID_BITS-1:0]  ram_rdata
);

  function automatic logic [IDX_BITS-1:0] slot_inc(input logic [IDX_BITS-1:0] s);
    slot_inc = (s == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [IDX_BITS-1:0] slot_add(input logic [IDX_BITS-1:0] h,
                                                    input logic [CNT_BITS-1:0] c);
    logic [CNT_BITS:0] sum;
    sum = (CNT_BITS+1)'(h) + (CNT_BITS+1)'(c);
    if (sum >= (CNT_BITS+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_BITS+1)'(QUEUE_DEPTH);
    end
    slot_add = sum[IDX_BITS-1:0];
  endfunction

  state_t              state;
  state_t              state_next;
  op_kind_t            kind_q;
  logic [ID_BITS-1:0]  id_q;
  logic [CNT_BITS-1:0] occ;
  logic [IDX_BITS-1:0] head;
  logic [CNT_BITS-1:0] rd_pos;
  logic [IDX_BITS-1:0] rd_slot;
  logic [IDX_BITS-1:0] dat_slot;
  logic [IDX_BITS-1:0] prev_slot;
  logic                found;
  logic                moved;
  logic                r_success;
  logic                r_idv;
  logic [ID_BITS-1:0]  r_id;
  logic                out_valid;
  logic                out_success;
  logic                out_idv;
  logic [ID_BITS-1:0]  out_id;
  logic [CNT_BITS-1:0] out_count;

  logic [IDX_BITS-1:0] tail_slot;
  logic                match;
  logic                scan_last;
  logic                out_free;
  logic                not_full;

  assign tail_slot = slot_add(head, occ);
  assign match     = (ram_rdata == id_q);
  assign scan_last = (rd_pos == occ);
  assign out_free  = !out_valid || res.ready;
  assign not_full  = (occ < CNT_BITS'(QUEUE_DEPTH));

  assign res.valid       = out_valid;
  assign res.success     = out_success;
  assign res.id_valid    = out_idv;
  assign res.returned_id = out_id;
  assign res.entry_count = out_count;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (kind_q)
          KIND_DELETE: state_next = (occ == '0) ? ST_DONE : ST_SCAN;
          KIND_ROTATE: state_next = (occ >= CNT_BITS'(MIN_ROTATE)) ? ST_FETCH : ST_DONE;
          KIND_PEEK:   state_next = (occ != '0) ? ST_FETCH : ST_DONE;
          default:     state_next = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_FETCH: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake and RAM controls
  always_comb begin
    cmd.ready = (state == ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = tail_slot;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = head;
    unique case (state)
      ST_EXEC: begin
        ram_wdata = id_q;
        ram_we    = (kind_q == KIND_APPEND) && not_full;
        ram_re    = (kind_q == KIND_DELETE) || (kind_q == KIND_ROTATE) ||
                    (kind_q == KIND_PEEK);
      end
      ST_SCAN: begin
        ram_re    = (rd_pos < occ);
        ram_raddr = rd_slot;
        ram_we    = found;
        ram_waddr = prev_slot;
      end
      ST_FETCH: begin
        ram_we = (kind_q == KIND_ROTATE);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      unique case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            kind_q <= op_kind_t'(cmd.kind);
            id_q   <= cmd.task_id;
          end
        end
        ST_EXEC: begin
          r_success <= 1'b0;
          r_idv     <= 1'b0;
          r_id      <= '0;
          rd_pos    <= CNT_BITS'(1);
          rd_slot   <= slot_inc(head);
          dat_slot  <= head;
          found     <= 1'b0;
          moved     <= 1'b0;
          unique case (kind_q)
            KIND_APPEND: begin
              if (not_full) begin
                occ       <= occ + 1'b1;
                r_success <= 1'b1;
              end
            end
            KIND_ROTATE, KIND_PEEK: r_success <= 1'b1;
            KIND_CLEAR: begin
              occ       <= '0;
              head      <= '0;
              r_success <= 1'b1;
            end
            default: begin
            end
          endcase
        end
        ST_SCAN: begin
          rd_pos    <= rd_pos + 1'b1;
          rd_slot   <= slot_inc(rd_slot);
          dat_slot  <= slot_inc(dat_slot);
          prev_slot <= dat_slot;
          if (found && !moved) begin
            moved <= 1'b1;
            r_idv <= 1'b1;
            r_id  <= ram_rdata;
          end
          if (!found && match) begin
            found <= 1'b1;
          end
          if (scan_last && (found || match)) begin
            occ       <= occ - 1'b1;
            r_success <= 1'b1;
          end
        end
        ST_FETCH: begin
          if (kind_q == KIND_PEEK) begin
            r_idv <= 1'b1;
            r_id  <= ram_rdata;
          end else begin
            head <= slot_inc(head);
          end
        end
        default: begin
        end
      endcase

      if (state == ST_DONE && out_free) begin
        out_valid   <= 1'b1;
        out_success <= r_success;
        out_idv     <= r_idv;
        out_id      <= r_id;
        out_count   <= occ;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/task_ready_queue.sv -----
// Task ready queue: a circular queue of task ids held in one RAM. Each command
// transfer is worked to completion before the next is taken. Every command passes
// the execute state and then the done state, which loads the result register; peek
// and rotate, with enough entries, add a fetch state (a RAM read and, for rotate,
// a write back), and delete on a non-empty queue adds a scan state that streams
// the entries from head to tail through the RAM's single read port, one per cycle,
// and shifts the entries behind the match one slot toward the head as they pass.
// The sequencer returns to idle before the next transfer; a result that finds the
// result register occupied holds the sequencer until that register drains. The
// result register lets in a new command while a result awaits its transfer.
`default_nettype none

module task_ready_queue import trq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS
) (
  input wire logic  clk,
  input wire logic  rst,
  trq_cmd_if.sink   cmd,
  trq_res_if.source res
);

  localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic                ram_we;
  logic [IDX_BITS-1:0] ram_waddr;
  logic [ID_BITS-1:0]  ram_wdata;
  logic                ram_re;
  logic [IDX_BITS-1:0] ram_raddr;
  logic [ID_BITS-1:0]  ram_rdata;

  trq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  trq_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.entry_count <= CNT_BITS'(QUEUE_DEPTH)))
    else $error("entry count above depth");

  a_idv_success: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.id_valid) |-> res.success)
    else $error("returned id without success");

  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.id_valid) |-> (res.returned_id == '0))
    else $error("returned id not cleared");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("command taken while busy");
`endif

endmodule

`default_nettype wire
